// ----- sv/mcsg_pkg.sv -----
`default_nettype none
package mcsg_pkg;

  localparam int CoordBits    = 11;
  localparam int RowBits      = 13;
  localparam int XFinalBits   = 12;
  localparam int ColorBits    = 24;
  localparam int RadiusBits   = 4;
  localparam int MaxRadiusDef = 15;
  localparam int RadiusReset  = 1;
  localparam int SpanLimit    = 48;
  localparam int CountBits    = $clog2(SpanLimit + 1);
  // a, b: b reaches about 12, a can drop to -1 on radius zero
  localparam int StepBits     = 6;
  localparam int ErrBits      = 10;

  typedef struct packed {
    logic [CoordBits-1:0] center_x;
    logic [CoordBits-1:0] center_y;
    logic [ColorBits-1:0] color;
    logic                 draw_enable;
  } point_t;

  typedef struct packed {
    logic signed [RowBits-1:0] row_y;
    logic [CoordBits-1:0]      x_first;
    logic [XFinalBits-1:0]     x_final;
    logic [ColorBits-1:0]      span_color;
    logic                      last_span;
  } span_t;

  typedef enum logic [1:0] {
    PH_LOW_POS  = 2'd0,
    PH_LOW_NEG  = 2'd1,
    PH_HIGH_POS = 2'd2,
    PH_HIGH_NEG = 2'd3
  } phase_t;

  typedef struct packed {
    logic start;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/midpoint_circle_span_generator.sv -----
// First span: the point loads the stepping registers, then the output register.
// One span per cycle while span_stall is low; four spans per step, up to 48 per
//   drawn point, from the single stepping datapath; draw_enable clear gives none.
// Output register lets the next point be accepted while the last span waits.
// Reset (rst, synchronous): radius = 1, controller idle, output register empty.
`default_nettype none
module midpoint_circle_span_generator
  import mcsg_pkg::*;
#(
  parameter int MAX_RADIUS = MaxRadiusDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [RadiusBits-1:0] cfg_wdata,
  input  wire logic                  point_valid,
  output logic                       point_stall,
  input  wire point_t                point,
  output logic                       span_valid,
  input  wire logic                  span_stall,
  output span_t                      span
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcsg_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .point_valid (point_valid),
    .draw_enable (point.draw_enable),
    .point_stall (point_stall),
    .span_stall  (span_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  mcsg_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .point      (point),
    .span_stall (span_stall),
    .cmd        (cmd),
    .stat       (stat),
    .span_valid (span_valid),
    .span       (span)
  );

endmodule
`default_nettype wire

// ----- sv/mcsg_ctrl.sv -----
`default_nettype none
module mcsg_ctrl
  import mcsg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     point_valid,
  input  wire logic     draw_enable,
  output logic          point_stall,
  input  wire logic     span_stall,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic {
    IDLE,
    RUN
  } state_t;

  state_t state;

  assign point_stall = (state == RUN);

  always_comb begin
    cmd.start = (state == IDLE) && point_valid && draw_enable;
    cmd.emit  = (state == RUN) && (!stat.out_valid || !span_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (cmd.start) state <= RUN;
        end
        RUN: begin
          if (cmd.emit && stat.last) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/mcsg_datapath.sv -----
`default_nettype none
module mcsg_datapath
  import mcsg_pkg::*;
#(
  parameter int MAX_RADIUS = MaxRadiusDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [RadiusBits-1:0] cfg_wdata,
  input  wire point_t                point,
  input  wire logic                  span_stall,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic                       span_valid,
  output span_t                      span
);

  localparam logic [RadiusBits-1:0] RMax = RadiusBits'(MAX_RADIUS);
  localparam logic [CoordBits-1:0]  CMask = CoordBits'((1 << CoordBits) - 1);

  logic [RadiusBits-1:0]      radius;
  logic [CoordBits-1:0]       cx, cy;
  logic [ColorBits-1:0]       color;
  logic signed [StepBits-1:0] a, b;
  logic signed [ErrBits-1:0]  dx, dy, err;
  phase_t                     phase;
  logic [CountBits-1:0]       count;

  logic [RadiusBits-1:0]      r_sat;
  logic signed [StepBits-1:0] a_next, b_next;
  logic signed [ErrBits-1:0]  dx_next, dy_next, err_next, err_mid;
  logic signed [ErrBits:0]    decide;
  logic                       last;
  logic signed [StepBits-1:0] coord;
  logic signed [RowBits-1:0]  row_base, row_off;

  assign r_sat = (radius > RMax) ? RMax : radius;

  // one midpoint step, applied after the fourth span
  always_comb begin
    b_next   = b + StepBits'(1);
    err_mid  = err + dy;
    dy_next  = dy + ErrBits'(2);
    decide   = {err_mid, 1'b0} + (ErrBits+1)'(dx);
    a_next   = a;
    err_next = err_mid;
    dx_next  = dx;
    if (decide > 0) begin
      a_next   = a - StepBits'(1);
      err_next = err_mid + dx;
      dx_next  = dx + ErrBits'(2);
    end
  end

  assign last = (phase == PH_HIGH_NEG) &&
                ((a_next < b_next) || (count == CountBits'(SpanLimit - 1)));

  always_comb begin
    stat.last      = last;
    stat.out_valid = span_valid;
  end

  always_comb begin
    row_base = RowBits'(cy);
    case (phase)
      PH_LOW_POS:  begin coord = b; row_off = RowBits'(b);  end
      PH_LOW_NEG:  begin coord = b; row_off = -RowBits'(b); end
      PH_HIGH_POS: begin coord = a; row_off = RowBits'(a);  end
      PH_HIGH_NEG: begin coord = a; row_off = -RowBits'(a); end
      default:     begin coord = a; row_off = RowBits'(a);  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RadiusBits'(RadiusReset);
    end else if (cfg_wen) begin
      radius <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cx    <= point.center_x & CMask;
      cy    <= point.center_y & CMask;
      color <= point.color;
      a     <= StepBits'(r_sat);
      b     <= '0;
      dx    <= ErrBits'(1) - ErrBits'({r_sat, 1'b0});
      dy    <= '0;
      err   <= '0;
      phase <= PH_LOW_POS;
      count <= '0;
    end else if (cmd.emit) begin
      count <= count + CountBits'(1);
      case (phase)
        PH_LOW_POS:  phase <= PH_LOW_NEG;
        PH_LOW_NEG:  phase <= PH_HIGH_POS;
        PH_HIGH_POS: phase <= PH_HIGH_NEG;
        default: begin
          phase <= PH_LOW_POS;
          a     <= a_next;
          b     <= b_next;
          dx    <= dx_next;
          dy    <= dy_next;
          err   <= err_next;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (cmd.emit) begin
      span_valid <= 1'b1;
    end else if (!span_stall) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      span.row_y      <= row_base + row_off;
      span.x_first    <= cx;
      span.x_final    <= XFinalBits'(cx) + XFinalBits'(coord[StepBits-2:0]);
      span.span_color <= color;
      span.last_span  <= last;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
module tb;
  import mcsg_pkg::*;

  localparam int CoordMax = (1 << CoordBits) - 1;
  localparam int SettleCycles = 8;
  localparam int StuckLimit = 5000;
  localparam int DrawnPerPhase = 85;

  // Expected spans per accepted request, in emission order.
  class span_scoreboard;
    span_t pending[$];
    span_t staged[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    function void stage_span(point_t p, int row, int coord);
      span_t s;
      if (staged.size() >= SpanLimit) return;
      s.row_y = RowBits'(row);
      s.x_first = p.center_x;
      s.x_final = XFinalBits'(int'(p.center_x) + coord);
      s.span_color = p.color;
      s.last_span = 1'b0;
      staged.push_back(s);
    endfunction

    // Midpoint stepping: four spans per step, low pair then high pair.
    function void note_point(point_t p, logic [RadiusBits-1:0] rad);
      int a, b, dx, dy, err, cy;
      span_t tail;
      if (!p.draw_enable) return;
      staged.delete();
      a = int'(rad);
      if (a > MaxRadiusDef) a = MaxRadiusDef;
      b = 0;
      dx = 1 - 2 * a;
      dy = 0;
      err = 0;
      cy = int'(p.center_y);
      while (a >= b && staged.size() < SpanLimit) begin
        stage_span(p, cy + b, b);
        stage_span(p, cy - b, b);
        stage_span(p, cy + a, a);
        stage_span(p, cy - a, a);
        b++;
        err += dy;
        dy += 2;
        if (2 * err + dx > 0) begin
          a--;
          err += dx;
          dx += 2;
        end
      end
      tail = staged.pop_back();
      tail.last_span = 1'b1;
      staged.push_back(tail);
      foreach (staged[i]) pending.push_back(staged[i]);
    endfunction

    task check_span(span_t got);
      span_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected span row %0d x %0d..%0d", got.row_y, got.x_first,
                         got.x_final));
        return;
      end
      want = pending.pop_front();
      if (got.row_y !== want.row_y)
        report($sformatf("row_y got %0d want %0d", got.row_y, want.row_y));
      if (got.x_first !== want.x_first)
        report($sformatf("x_first got %0d want %0d", got.x_first, want.x_first));
      if (got.x_final !== want.x_final)
        report($sformatf("x_final got %0d want %0d", got.x_final, want.x_final));
      if (got.span_color !== want.span_color)
        report($sformatf("span_color got %h want %h", got.span_color, want.span_color));
      if (got.last_span !== want.last_span)
        report($sformatf("last_span got %b want %b", got.last_span, want.last_span));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [RadiusBits-1:0] cfg_wdata = '0;
  logic point_valid = 1'b0;
  point_t point = '0;
  logic span_stall = 1'b0;
  logic point_stall;
  logic span_valid;
  span_t span;

  span_scoreboard board;
  logic [RadiusBits-1:0] radius_now = RadiusBits'(RadiusReset);
  int tx_idle = 0;
  int rx_idle = 0;
  int stuck = 0;

  always #2 clk = ~clk;

  midpoint_circle_span_generator #(
    .MAX_RADIUS(MaxRadiusDef)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point(point),
    .span_valid(span_valid),
    .span_stall(span_stall),
    .span(span)
  );

  always @(negedge clk) begin
    span_stall <= ($urandom_range(0, 99) < rx_idle);
  end

  always @(posedge clk) begin
    if (!rst && span_valid && !span_stall) board.check_span(span);
  end

  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (span_valid && !span_stall)) begin
      stuck <= 0;
    end else if (stuck + 1 >= StuckLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  function automatic logic [CoordBits-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: begin
        return CoordBits'($urandom_range(0, 15));
      end
      1: begin
        return CoordBits'($urandom_range(CoordMax - 15, CoordMax));
      end
      default: begin
        return CoordBits'($urandom_range(0, CoordMax));
      end
    endcase
  endfunction

  function automatic point_t make_point(int x, int y, int c, logic en);
    point_t p;
    p.center_x = CoordBits'(x);
    p.center_y = CoordBits'(y);
    p.color = ColorBits'(c);
    p.draw_enable = en;
    return p;
  endfunction

  function automatic point_t random_point(int draw_pct);
    point_t p;
    p.center_x = pick_coord();
    p.center_y = pick_coord();
    p.color = ColorBits'($urandom);
    p.draw_enable = ($urandom_range(0, 99) < draw_pct);
    return p;
  endfunction

  // Called and returns at a falling edge; valid is left high for the next request.
  task automatic send_point(point_t p);
    while ($urandom_range(0, 99) < tx_idle) begin
      point_valid <= 1'b0;
      point <= random_point(50);
      @(negedge clk);
    end
    point_valid <= 1'b1;
    point <= p;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    board.note_point(p, radius_now);
    @(negedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    // a point with draw_enable clear may still be in flight
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_radius(logic [RadiusBits-1:0] r);
    point_valid <= 1'b0;
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= r;
    radius_now = r;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    int drawn;
    int cfg_mark;
    point_t p;
    board = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle = 14;
    rx_idle = 71;

    // reset radius, field extremes and a skipped point
    send_point(make_point(0, 0, 0, 1'b1));
    send_point(make_point(CoordMax, CoordMax, 24'hFFFFFF, 1'b1));
    send_point(make_point(CoordMax, CoordMax, 24'hFFFFFF, 1'b0));
    send_point(make_point(11'h555, 11'h2AA, 24'hAAAAAA, 1'b1));
    send_point(make_point(11'h2AA, 11'h555, 24'h555555, 1'b1));

    // zero radius: four single-pixel spans on the center row
    set_radius(4'd0);
    send_point(make_point(100, 0, 24'h0F0F0F, 1'b1));
    send_point(make_point(CoordMax, CoordMax, 24'hF0F0F0, 1'b1));
    send_point(make_point(7, 7, 24'h123456, 1'b0));
    send_point(make_point(1, 2, 24'h654321, 1'b1));

    // largest radius: rows below zero and above the coordinate range
    set_radius(4'd15);
    send_point(make_point(CoordMax, 0, 24'h123456, 1'b1));
    send_point(make_point(0, CoordMax, 24'hABCDEF, 1'b1));
    send_point(make_point(1024, 7, 24'hFFFFFF, 1'b1));
    send_point(make_point(3, 3, 24'h000001, 1'b0));
    send_point(make_point(5, CoordMax - 7, 24'h800000, 1'b1));

    set_radius(4'd7);
    send_point(make_point(1023, 1024, 24'h7FFFFF, 1'b1));
    send_point(make_point(8, 2040, 24'h010203, 1'b1));

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          tx_idle = 14;
          rx_idle = 71;
        end
        1: begin
          tx_idle = 71;
          rx_idle = 14;
        end
        default: begin
          tx_idle = 0;
          rx_idle = 0;
        end
      endcase
      drawn = 0;
      cfg_mark = -1;
      while (drawn < DrawnPerPhase) begin
        if (drawn % 25 == 0 && cfg_mark != drawn) begin
          cfg_mark = drawn;
          if (drawn == 0 && ph == 0) set_radius(4'd15);
          else if (drawn == 0 && ph == 1) set_radius(4'd0);
          else set_radius(RadiusBits'($urandom_range(0, 15)));
        end
        p = random_point(90);
        if (p.draw_enable) drawn++;
        send_point(p);
      end
    end

    point_valid <= 1'b0;
    drain();
    repeat (16) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/mcsg_pkg.sv
sv/mcsg_ctrl.sv
sv/mcsg_datapath.sv
sv/midpoint_circle_span_generator.sv
tb/tb.sv
